FILE: design/msr_pkg.sv
`timescale 1ns / 1ps

package msr_pkg;

  // Request kinds
  typedef enum logic [1:0] {
    REQ_TICK   = 2'd0,
    REQ_SAMPLE = 2'd1,
    REQ_MANUAL = 2'd2,
    REQ_AUTO   = 2'd3
  } req_type_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_TARGET_SPEED = 3'd0,
    CFG_MIN_DUTY     = 3'd1,
    CFG_MAX_DUTY     = 3'd2,
    CFG_START_DUTY   = 3'd3,
    CFG_STALE_MS     = 3'd4,
    CFG_FULL_STALL   = 3'd5,
    CFG_HOLD_MS      = 3'd6
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Reset values of the registers
  localparam logic [11:0] RstTargetSpeed = 12'd300;
  localparam logic [7:0]  RstMinDuty     = 8'd130;
  localparam logic [7:0]  RstMaxDuty     = 8'd255;
  localparam logic [7:0]  RstStartDuty   = 8'd180;
  localparam logic [15:0] RstStaleMs     = 16'd2000;
  localparam logic [15:0] RstFullStallMs = 16'd8000;
  localparam logic [15:0] RstHoldMs      = 16'd300;

  // Regulation constants
  localparam logic [11:0] GoodSpeed = 12'd150;
  localparam logic [7:0]  RampStep  = 8'd5;

  localparam logic signed [12:0] ErrBig    = 13'sd50;
  localparam logic signed [12:0] ErrMid    = 13'sd20;
  localparam logic signed [12:0] Deadband  = 13'sd15;
  localparam logic signed [12:0] ErrNegBig = -13'sd80;
  localparam logic signed [12:0] ErrNegDb  = -13'sd15;

  localparam logic signed [3:0] StepBig    = 4'sd5;
  localparam logic signed [3:0] StepMid    = 4'sd3;
  localparam logic signed [3:0] StepSmall  = 4'sd1;
  localparam logic signed [3:0] StepNegBig = -4'sd2;
  localparam logic signed [3:0] StepNeg    = -4'sd1;

  typedef struct packed {
    req_type_e   req_type;
    logic [31:0] now_ms;
    logic [11:0] speed_sample;
    logic [7:0]  manual_duty;
    logic        enable_auto;
  } in_t;

  typedef struct packed {
    logic [7:0] drive_duty;
    logic       regulating;
    logic       in_restart;
    logic       speed_stale;
  } out_t;

  // Live register values seen by the regulator
  typedef struct packed {
    logic [11:0] target_speed;
    logic [7:0]  min_duty;
    logic [7:0]  max_duty;
    logic [15:0] stale_timeout_ms;
    logic [15:0] full_stall_ms;
    logic [15:0] restart_hold_ms;
  } cfg_t;

  // Asymmetric step table: faster up than down, zero inside the deadband
  function automatic logic signed [3:0] step_for(logic signed [12:0] err);
    logic signed [3:0] adj;
    if (err > ErrBig)         adj = StepBig;
    else if (err > ErrMid)    adj = StepMid;
    else if (err > Deadband)  adj = StepSmall;
    else if (err < ErrNegBig) adj = StepNegBig;
    else if (err < ErrNegDb)  adj = StepNeg;
    else                      adj = 4'sd0;
    return adj;
  endfunction

endpackage

FILE: design/msr_cfg.sv
`timescale 1ns / 1ps

module msr_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [msr_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [msr_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output msr_pkg::cfg_t                 cfg_o
);

  msr_pkg::cfg_t cfg_q, cfg_d;

  // Decode the write; start duty only matters at reset, so writes to it are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (msr_pkg::cfg_idx_e'(cfg_idx_i))
        msr_pkg::CFG_TARGET_SPEED: cfg_d.target_speed     = cfg_wdata_i[11:0];
        msr_pkg::CFG_MIN_DUTY:     cfg_d.min_duty         = cfg_wdata_i[7:0];
        msr_pkg::CFG_MAX_DUTY:     cfg_d.max_duty         = cfg_wdata_i[7:0];
        msr_pkg::CFG_START_DUTY:   cfg_d = cfg_q;
        msr_pkg::CFG_STALE_MS:     cfg_d.stale_timeout_ms = cfg_wdata_i;
        msr_pkg::CFG_FULL_STALL:   cfg_d.full_stall_ms    = cfg_wdata_i;
        msr_pkg::CFG_HOLD_MS:      cfg_d.restart_hold_ms  = cfg_wdata_i;
        default:                   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_speed     <= msr_pkg::RstTargetSpeed;
      cfg_q.min_duty         <= msr_pkg::RstMinDuty;
      cfg_q.max_duty         <= msr_pkg::RstMaxDuty;
      cfg_q.stale_timeout_ms <= msr_pkg::RstStaleMs;
      cfg_q.full_stall_ms    <= msr_pkg::RstFullStallMs;
      cfg_q.restart_hold_ms  <= msr_pkg::RstHoldMs;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: design/msr_core.sv
`timescale 1ns / 1ps

module msr_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  msr_pkg::cfg_t  cfg_i,
  input  msr_pkg::in_t   req_i,
  input  logic           fire_i,
  output msr_pkg::out_t  rsp_o
);

  logic [7:0]  duty_level_q, duty_level_d;
  logic [7:0]  applied_duty_q, applied_duty_d;
  logic [11:0] measured_speed_q, measured_speed_d;
  logic [31:0] sample_time_q, sample_time_d;
  logic        sample_seen_q, sample_seen_d;
  logic [7:0]  good_duty_q, good_duty_d;
  logic [31:0] at_max_since_q, at_max_since_d;
  logic        at_max_valid_q, at_max_valid_d;
  logic        restart_active_q, restart_active_d;
  logic [31:0] restart_time_q, restart_time_d;
  logic        auto_on_q, auto_on_d;

  logic [31:0]       now;
  logic              stale_pre;
  logic [31:0]       hold_elapsed;
  logic [31:0]       max_elapsed;
  logic [8:0]        ramp_sum;
  logic signed [12:0] err;
  logic signed [3:0]  adj;
  logic signed [9:0]  reg_sum;

  assign now          = req_i.now_ms;
  assign stale_pre    = !sample_seen_q ||
                        ((now - sample_time_q) > {16'd0, cfg_i.stale_timeout_ms});
  assign hold_elapsed = now - restart_time_q;
  assign max_elapsed  = now - at_max_since_q;
  assign ramp_sum     = {1'b0, duty_level_q} + {1'b0, msr_pkg::RampStep};
  assign err          = $signed({1'b0, cfg_i.target_speed}) -
                        $signed({1'b0, measured_speed_q});
  assign adj          = msr_pkg::step_for(err);
  assign reg_sum      = $signed({2'b00, duty_level_q}) + {{6{adj[3]}}, adj};

  // Next state for the request at the head of the pipe
  always_comb begin
    duty_level_d     = duty_level_q;
    applied_duty_d   = applied_duty_q;
    measured_speed_d = measured_speed_q;
    sample_time_d    = sample_time_q;
    sample_seen_d    = sample_seen_q;
    good_duty_d      = good_duty_q;
    at_max_since_d   = at_max_since_q;
    at_max_valid_d   = at_max_valid_q;
    restart_active_d = restart_active_q;
    restart_time_d   = restart_time_q;
    auto_on_d        = auto_on_q;

    case (req_i.req_type)
      msr_pkg::REQ_TICK: begin
        if (auto_on_q) begin
          if (restart_active_q) begin
            // End the power-cycle hold once its time is up
            if (hold_elapsed >= {16'd0, cfg_i.restart_hold_ms}) begin
              restart_active_d = 1'b0;
              duty_level_d     = good_duty_q;
              applied_duty_d   = good_duty_q;
              at_max_valid_d   = 1'b0;
            end
          end else if (stale_pre) begin
            if ((duty_level_q >= cfg_i.max_duty) && at_max_valid_q &&
                (max_elapsed > {16'd0, cfg_i.full_stall_ms})) begin
              // Stalled at maximum too long: cut the drive and start the hold
              applied_duty_d   = 8'd0;
              restart_active_d = 1'b1;
              restart_time_d   = now;
            end else if (duty_level_q >= cfg_i.max_duty) begin
              // Start timing the stay at maximum
              if (!at_max_valid_q) begin
                at_max_since_d = now;
                at_max_valid_d = 1'b1;
              end
            end else begin
              // Ramp toward maximum while no fresh speed is known
              duty_level_d   = (ramp_sum > {1'b0, cfg_i.max_duty}) ?
                               cfg_i.max_duty : ramp_sum[7:0];
              applied_duty_d = duty_level_d;
            end
          end else begin
            // Fresh speed: step by the table, clamp with min taking priority
            at_max_valid_d = 1'b0;
            if (adj != 4'sd0) begin
              if (reg_sum < $signed({2'b00, cfg_i.min_duty})) begin
                duty_level_d = cfg_i.min_duty;
              end else if (reg_sum > $signed({2'b00, cfg_i.max_duty})) begin
                duty_level_d = cfg_i.max_duty;
              end else begin
                duty_level_d = reg_sum[7:0];
              end
              applied_duty_d = duty_level_d;
            end
          end
        end
      end
      msr_pkg::REQ_SAMPLE: begin
        measured_speed_d = req_i.speed_sample;
        sample_time_d    = now;
        sample_seen_d    = 1'b1;
        if ((req_i.speed_sample > msr_pkg::GoodSpeed) &&
            (duty_level_q >= cfg_i.min_duty)) begin
          good_duty_d = duty_level_q;
        end
      end
      msr_pkg::REQ_MANUAL: begin
        duty_level_d   = req_i.manual_duty;
        applied_duty_d = req_i.manual_duty;
        auto_on_d      = 1'b0;
      end
      msr_pkg::REQ_AUTO: begin
        auto_on_d = req_i.enable_auto;
      end
      default: begin
        auto_on_d = auto_on_q;
      end
    endcase
  end

  // Result from the updated state
  always_comb begin
    rsp_o.drive_duty  = applied_duty_d;
    rsp_o.regulating  = auto_on_d;
    rsp_o.in_restart  = restart_active_d;
    rsp_o.speed_stale = !sample_seen_d ||
                        ((now - sample_time_d) > {16'd0, cfg_i.stale_timeout_ms});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_level_q     <= msr_pkg::RstStartDuty;
      applied_duty_q   <= msr_pkg::RstStartDuty;
      measured_speed_q <= '0;
      sample_time_q    <= '0;
      sample_seen_q    <= 1'b0;
      good_duty_q      <= msr_pkg::RstStartDuty;
      at_max_since_q   <= '0;
      at_max_valid_q   <= 1'b0;
      restart_active_q <= 1'b0;
      restart_time_q   <= '0;
      auto_on_q        <= 1'b1;
    end else if (fire_i) begin
      duty_level_q     <= duty_level_d;
      applied_duty_q   <= applied_duty_d;
      measured_speed_q <= measured_speed_d;
      sample_time_q    <= sample_time_d;
      sample_seen_q    <= sample_seen_d;
      good_duty_q      <= good_duty_d;
      at_max_since_q   <= at_max_since_d;
      at_max_valid_q   <= at_max_valid_d;
      restart_active_q <= restart_active_d;
      restart_time_q   <= restart_time_d;
      auto_on_q        <= auto_on_d;
    end
  end

endmodule

FILE: design/motor_speed_regulator_stall_recovery_unit.sv
`timescale 1ns / 1ps

// Stepped speed regulator with stall recovery. Each request (regulation tick,
// speed sample, manual duty, auto enable) yields exactly one result carrying
// the applied duty and the regulating, restart and stale flags. A request is
// taken every clock cycle while the result side is not stalled: it lands in
// an input register, and when the result register is free the regulator
// state and the result register are updated from it. Throughput is one
// request per cycle, set by the state update (step table, clamp and
// elapsed-time compares) that each request must finish before the next one
// reads the state; it drops only while the result register is held by
// out_ready_i. Write the registers through the cfg port only while the block
// is idle (the block itself does not enforce this); they take effect on
// the next request.
module motor_speed_regulator_stall_recovery_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  msr_pkg::in_t                  in_req_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output msr_pkg::out_t                 out_rsp_o,
  input  logic                          cfg_we_i,
  input  logic [msr_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [msr_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  msr_pkg::cfg_t cfg;
  msr_pkg::in_t  req_q;
  logic          req_valid_q;
  msr_pkg::out_t rsp_d, rsp_q;
  logic          rsp_valid_q;
  logic          out_free;
  logic          fire;

  assign out_free   = !rsp_valid_q || out_ready_i;
  assign fire       = req_valid_q && out_free;
  assign in_ready_o = !req_valid_q || out_free;

  msr_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  msr_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .req_i  (req_q),
    .fire_i (fire),
    .rsp_o  (rsp_d)
  );

  // Hold the incoming request until the regulator takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      req_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      req_q <= in_req_i;
    end
  end

  // Advance the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (out_free) begin
      rsp_valid_q <= req_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = rsp_valid_q;
  assign out_rsp_o   = rsp_q;

endmodule

FILE: design/msr_checker.sv
`timescale 1ns / 1ps

module msr_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input msr_pkg::out_t out_rsp_o
);

  logic last_restart_q;

  // Track the restart flag of the last delivered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_restart_q <= 1'b0;
    end else if (out_valid_o && out_ready_i) begin
      last_restart_q <= out_rsp_o.in_restart;
    end
  end

  // A stalled result holds its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("result changed while stalled");

  // Input backpressure only comes from a stalled, full result stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("request refused without output stall");

  // Entering the power-cycle hold cuts the drive
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.in_restart && !last_restart_q |->
      out_rsp_o.drive_duty == 8'd0)
    else $error("restart entered with nonzero drive");

  // No result appears out of an empty pipe
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && !in_valid_i ##1 !in_valid_i |=> !out_valid_o || in_ready_o)
    else $error("unexpected result");

endmodule

bind motor_speed_regulator_stall_recovery_unit msr_checker u_msr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_rsp_o   (out_rsp_o)
);

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import msr_pkg::*;

  localparam int NumPhases    = 7;
  localparam int PhaseItems   = 280;
  localparam int StuckLimit   = 1000;
  localparam int SettleCycles = 10;

  // One directed request, with its result typed in where it is obvious
  typedef struct packed {
    in_t  req;
    logic typed;
    out_t rsp;
  } dir_row_t;

  localparam dir_row_t Directed [24] = '{
    // stale after reset: ramp from the start duty
    '{'{REQ_TICK,   32'd0,         12'd0,    8'd0,   1'b0}, 1'b1, '{8'd185, 1'b1, 1'b0, 1'b1}},
    '{'{REQ_SAMPLE, 32'd100,       12'd4095, 8'd0,   1'b0}, 1'b1, '{8'd185, 1'b1, 1'b0, 1'b0}},
    '{'{REQ_TICK,   32'd200,       12'd0,    8'd0,   1'b0}, 1'b1, '{8'd183, 1'b1, 1'b0, 1'b0}},
    '{'{REQ_SAMPLE, 32'd300,       12'd0,    8'd0,   1'b0}, 1'b1, '{8'd183, 1'b1, 1'b0, 1'b0}},
    '{'{REQ_TICK,   32'd400,       12'd0,    8'd0,   1'b0}, 1'b1, '{8'd188, 1'b1, 1'b0, 1'b0}},
    // deadband edges around the default target
    '{'{REQ_SAMPLE, 32'd500,       12'd284,  8'd0,   1'b0}, 1'b1, '{8'd188, 1'b1, 1'b0, 1'b0}},
    '{'{REQ_TICK,   32'd600,       12'd0,    8'd0,   1'b0}, 1'b0, '0},
    '{'{REQ_SAMPLE, 32'd700,       12'd315,  8'd0,   1'b0}, 1'b0, '0},
    '{'{REQ_TICK,   32'd800,       12'd0,    8'd0,   1'b0}, 1'b0, '0},
    // manual write drops auto, tick is then ignored
    '{'{REQ_MANUAL, 32'd900,       12'd0,    8'd255, 1'b1}, 1'b1, '{8'd255, 1'b0, 1'b0, 1'b0}},
    '{'{REQ_TICK,   32'd1000,      12'd0,    8'd0,   1'b0}, 1'b1, '{8'd255, 1'b0, 1'b0, 1'b0}},
    '{'{REQ_AUTO,   32'd1100,      12'd0,    8'd0,   1'b1}, 1'b1, '{8'd255, 1'b1, 1'b0, 1'b0}},
    // stall at max across the time wrap, then power cycle
    '{'{REQ_TICK,   32'hFFFF_F000, 12'd0,    8'd0,   1'b0}, 1'b1, '{8'd255, 1'b1, 1'b0, 1'b1}},
    '{'{REQ_TICK,   32'h0000_1000, 12'd0,    8'd0,   1'b0}, 1'b1, '{8'd0,   1'b1, 1'b1, 1'b1}},
    '{'{REQ_TICK,   32'h0000_112B, 12'd0,    8'd0,   1'b0}, 1'b1, '{8'd0,   1'b1, 1'b1, 1'b1}},
    // manual write during the hold keeps the hold flag
    '{'{REQ_MANUAL, 32'h0000_112C, 12'd0,    8'h5A,  1'b0}, 1'b1, '{8'h5A,  1'b0, 1'b1, 1'b1}},
    '{'{REQ_TICK,   32'h0000_2000, 12'd0,    8'd0,   1'b0}, 1'b1, '{8'h5A,  1'b0, 1'b1, 1'b1}},
    '{'{REQ_AUTO,   32'h0000_2001, 12'd0,    8'd0,   1'b0}, 1'b1, '{8'h5A,  1'b0, 1'b1, 1'b1}},
    '{'{REQ_AUTO,   32'h0000_2002, 12'd0,    8'd0,   1'b1}, 1'b1, '{8'h5A,  1'b1, 1'b1, 1'b1}},
    // hold completes, restart at the good duty
    '{'{REQ_TICK,   32'h0000_2003, 12'd0,    8'd0,   1'b0}, 1'b0, '0},
    '{'{REQ_SAMPLE, 32'h0000_2004, 12'd151,  8'd0,   1'b0}, 1'b0, '0},
    '{'{REQ_SAMPLE, 32'h0000_2005, 12'd150,  8'd0,   1'b0}, 1'b0, '0},
    '{'{REQ_TICK,   32'h0000_2006, 12'd0,    8'd0,   1'b0}, 1'b0, '0},
    '{'{REQ_TICK,   32'hFFFF_FFFF, 12'd0,    8'd0,   1'b0}, 1'b0, '0}
  };

  // Register sets in index order: target, min, max, start, stale, full stall, hold
  localparam logic [15:0] PhaseRegs [NumPhases][7] = '{
    '{16'd300,  16'd130,  16'd255,  16'd40,   16'd100,  16'd400,  16'd60},
    '{16'd0,    16'd0,    16'd255,  16'd255,  16'd0,    16'd0,    16'd0},
    '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
    '{16'd1000, 16'd200,  16'd100,  16'd7,    16'd50,   16'd150,  16'd20},
    '{16'd150,  16'd60,   16'd200,  16'd128,  16'd30,   16'd100,  16'd10},
    '{16'd2500, 16'd0,    16'd0,    16'd99,   16'd20,   16'd60,   16'd5},
    '{16'd800,  16'd100,  16'd230,  16'd1,    16'd400,  16'd1200, 16'd200}
  };

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  in_t                 in_req;
  logic                out_valid;
  logic                out_ready;
  out_t                out_rsp;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;

  // Regulator state as the testbench sees it
  logic [7:0]  duty_lvl, drive_lvl, good_lvl;
  logic [11:0] spd_meas;
  logic [31:0] spd_time, max_since, hold_start;
  logic        spd_seen, max_seen, hold_on, regulate_on;

  // Register copies; the start duty only matters at the single reset
  logic [11:0] tgt_rpm;
  logic [7:0]  lo_duty, hi_duty, boot_duty;
  logic [15:0] stale_lim, stall_lim, hold_lim;

  out_t pending_status [$];
  int   n_errors       = 0;
  int   src_gap_pct    = 20;
  int   sink_stall_pct = 20;
  int   stuck_cycles   = 0;

  motor_speed_regulator_stall_recovery_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_rsp_o   (out_rsp),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic sample_stale(logic [31:0] t);
    logic [31:0] age;
    age = t - spd_time;
    return !spd_seen || (age > {16'd0, stale_lim});
  endfunction

  function automatic void regulate_tick(logic [31:0] t);
    logic [31:0] age;
    int err, adj, v;
    if (!regulate_on) return;
    // hold the drive at zero until the restart time is up
    if (hold_on) begin
      age = t - hold_start;
      if (age < {16'd0, hold_lim}) return;
      hold_on   = 1'b0;
      duty_lvl  = good_lvl;
      drive_lvl = good_lvl;
      max_seen  = 1'b0;
      return;
    end
    // no fresh speed: ramp up, power cycle after a long stretch at max
    if (sample_stale(t)) begin
      age = t - max_since;
      if (duty_lvl >= hi_duty) begin
        if (!max_seen) begin
          max_since = t;
          max_seen  = 1'b1;
        end else if (age > {16'd0, stall_lim}) begin
          drive_lvl  = '0;
          hold_on    = 1'b1;
          hold_start = t;
          return;
        end
      end
      if (duty_lvl < hi_duty) begin
        v = int'(duty_lvl) + int'(RampStep);
        duty_lvl  = (v > int'(hi_duty)) ? hi_duty : 8'(v);
        drive_lvl = duty_lvl;
      end
      return;
    end
    // fresh speed: step toward the target outside the deadband
    max_seen = 1'b0;
    err = int'(tgt_rpm) - int'(spd_meas);
    if (err > ErrBig)         adj = StepBig;
    else if (err > ErrMid)    adj = StepMid;
    else if (err > Deadband)  adj = StepSmall;
    else if (err < ErrNegBig) adj = StepNegBig;
    else if (err < ErrNegDb)  adj = StepNeg;
    else                      adj = 0;
    if (adj != 0) begin
      v = int'(duty_lvl) + adj;
      // lower bound first, so min wins when it sits above max
      if (v < int'(lo_duty)) v = int'(lo_duty);
      else if (v > int'(hi_duty)) v = int'(hi_duty);
      duty_lvl  = 8'(v);
      drive_lvl = duty_lvl;
    end
  endfunction

  function automatic out_t predict_status(in_t r);
    out_t o;
    case (r.req_type)
      REQ_TICK: regulate_tick(r.now_ms);
      REQ_SAMPLE: begin
        spd_meas = r.speed_sample;
        spd_time = r.now_ms;
        spd_seen = 1'b1;
        if (r.speed_sample > GoodSpeed && duty_lvl >= lo_duty) good_lvl = duty_lvl;
      end
      REQ_MANUAL: begin
        duty_lvl    = r.manual_duty;
        drive_lvl   = r.manual_duty;
        regulate_on = 1'b0;
      end
      default: regulate_on = r.enable_auto;
    endcase
    o.drive_duty  = drive_lvl;
    o.regulating  = regulate_on;
    o.in_restart  = hold_on;
    o.speed_stale = sample_stale(r.now_ms);
    return o;
  endfunction

  // Offer one request, optionally after a gap, and log its expected status
  task automatic send_request(input in_t r, input logic typed, input out_t typed_rsp);
    out_t guess;
    int n;
    if ($urandom_range(0, 99) < src_gap_pct) begin
      in_valid <= 1'b0;
      n = $urandom_range(1, 7);
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk); while (!in_ready);
    guess = predict_status(r);
    pending_status.push_back(typed ? typed_rsp : guess);
  endtask

  // Drop valid and hold until every expected status has come back
  task automatic wait_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_status.size() != 0);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_TARGET_SPEED: tgt_rpm   = val[11:0];
      CFG_MIN_DUTY:     lo_duty   = val[7:0];
      CFG_MAX_DUTY:     hi_duty   = val[7:0];
      CFG_START_DUTY:   boot_duty = val[7:0];
      CFG_STALE_MS:     stale_lim = val;
      CFG_FULL_STALL:   stall_lim = val;
      default:          hold_lim  = val;
    endcase
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endtask

  // Compare each returned status with the oldest expectation
  always @(posedge clk) begin : status_check
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_status.size() == 0) begin
        $error("status with no request pending: drive_duty %0d", out_rsp.drive_duty);
        n_errors++;
      end else begin
        want = pending_status.pop_front();
        check_field("drive_duty", want.drive_duty, out_rsp.drive_duty);
        check_field("regulating", 8'(want.regulating), 8'(out_rsp.regulating));
        check_field("in_restart", 8'(want.in_restart), 8'(out_rsp.in_restart));
        check_field("speed_stale", 8'(want.speed_stale), 8'(out_rsp.speed_stale));
      end
    end
  end

  // Stall the result side in random bursts
  initial begin : sink_ready
    int n;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      n = $urandom_range(1, 7);
      if ($urandom_range(0, 99) < sink_stall_pct) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        n = $urandom_range(1, 12);
      end
      repeat (n) @(posedge clk);
    end
  end

  // Count cycles in which no request and no status moves
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (stuck_cycles >= StuckLimit);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    in_t r;
    int pick, dt_cap, v;
    logic starved;
    logic [31:0] t_ms;
    in_valid  <= 1'b0;
    in_req    <= '0;
    cfg_we    <= 1'b0;
    cfg_idx   <= '0;
    cfg_wdata <= '0;
    rst_n     <= 1'b0;
    tgt_rpm     = RstTargetSpeed;
    lo_duty     = RstMinDuty;
    hi_duty     = RstMaxDuty;
    boot_duty   = RstStartDuty;
    stale_lim   = RstStaleMs;
    stall_lim   = RstFullStallMs;
    hold_lim    = RstHoldMs;
    duty_lvl    = boot_duty;
    drive_lvl   = boot_duty;
    good_lvl    = boot_duty;
    spd_meas    = '0;
    spd_time    = '0;
    spd_seen    = 1'b0;
    max_since   = '0;
    max_seen    = 1'b0;
    hold_on     = 1'b0;
    hold_start  = '0;
    regulate_on = 1'b1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed table
    for (int i = 0; i < $size(Directed); i++) begin
      send_request(Directed[i].req, Directed[i].typed, Directed[i].rsp);
    end

    // Random phases, each under its own register set
    t_ms    = $urandom;
    starved = 1'b0;
    for (int ph = 0; ph < NumPhases; ph++) begin
      wait_results();
      for (int k = 0; k < 7; k++) write_reg(cfg_idx_e'(k), PhaseRegs[ph][k]);
      cfg_we <= 1'b0;
      dt_cap = int'(stale_lim >> 2) + 3;
      if (ph == NumPhases - 1) begin
        src_gap_pct    = 0;
        sink_stall_pct = 0;
      end else begin
        src_gap_pct    = $urandom_range(0, 35);
        sink_stall_pct = $urandom_range(0, 35);
      end
      for (int n = 0; n < PhaseItems; n++) begin
        // alternate fed stretches with sample-starved ones
        if ($urandom_range(0, starved ? 59 : 29) == 0) starved = !starved;
        if ($urandom_range(0, 199) == 0) wait_results();
        // advance time, with an occasional jump anywhere
        if ($urandom_range(0, 49) == 0) t_ms = $urandom;
        else t_ms = t_ms + $urandom_range(0, dt_cap);
        r.now_ms       = t_ms;
        r.speed_sample = 12'($urandom);
        r.manual_duty  = 8'($urandom);
        r.enable_auto  = ($urandom_range(0, 99) < 85);
        pick = $urandom_range(0, 99);
        if (starved) begin
          r.req_type = (pick < 92) ? REQ_TICK : REQ_AUTO;
        end else if (pick < 50) begin
          r.req_type = REQ_TICK;
        end else if (pick < 85) begin
          r.req_type = REQ_SAMPLE;
          // most samples land near the target
          if (pick < 70) begin
            v = int'(tgt_rpm) + int'($urandom_range(0, 200)) - 100;
            r.speed_sample = (v < 0) ? 12'd0 : (v > 4095) ? 12'd4095 : 12'(v);
          end
        end else if (pick < 91) begin
          r.req_type = REQ_MANUAL;
        end else begin
          r.req_type = REQ_AUTO;
        end
        send_request(r, 1'b0, '0);
      end
    end

    wait_results();
    repeat (SettleCycles) @(posedge clk);
    if (n_errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: filelist.f
design/msr_pkg.sv
design/msr_cfg.sv
design/msr_core.sv
design/motor_speed_regulator_stall_recovery_unit.sv
design/msr_checker.sv
test/tb_top.sv
